[design/kns_pkg.sv]
package kns_pkg;

  localparam int unsigned IDENT_BYTES = 8;
  localparam int unsigned IDX_W       = $clog2(IDENT_BYTES);
  localparam int unsigned CNT_W       = $clog2(IDENT_BYTES + 1);
  localparam int unsigned TEXT_W      = 8 * IDENT_BYTES;

  // token kinds
  localparam logic [4:0] KIND_END      = 5'd0;
  localparam logic [4:0] KIND_NUMBER   = 5'd1;
  localparam logic [4:0] KIND_IDENT    = 5'd2;
  localparam logic [4:0] KIND_SPAWN    = 5'd3;
  localparam logic [4:0] KIND_EVOLVE   = 5'd4;
  localparam logic [4:0] KIND_FITNESS  = 5'd5;
  localparam logic [4:0] KIND_PRESSURE = 5'd6;
  localparam logic [4:0] KIND_PRINT    = 5'd7;
  localparam logic [4:0] KIND_LBRACK   = 5'd8;
  localparam logic [4:0] KIND_RBRACK   = 5'd9;
  localparam logic [4:0] KIND_LPAREN   = 5'd10;
  localparam logic [4:0] KIND_RPAREN   = 5'd11;
  localparam logic [4:0] KIND_PLUS     = 5'd12;
  localparam logic [4:0] KIND_MINUS    = 5'd13;
  localparam logic [4:0] KIND_STAR     = 5'd14;
  localparam logic [4:0] KIND_SLASH    = 5'd15;
  localparam logic [4:0] KIND_EQUAL    = 5'd16;

  // scanner modes
  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_NUM   = 2'd1;
  localparam logic [1:0] MODE_IDENT = 2'd2;

  localparam logic [7:0] CHAR_NUL = 8'h00;

  // keywords packed first character in lowest byte
  localparam logic [TEXT_W-1:0] KW_SPAWN    = 64'h0000_006E_7761_7073;
  localparam logic [TEXT_W-1:0] KW_EVOLVE   = 64'h0000_6576_6C6F_7665;
  localparam logic [TEXT_W-1:0] KW_FITNESS  = 64'h0073_7365_6E74_6966;
  localparam logic [TEXT_W-1:0] KW_PRESSURE = 64'h6572_7573_7365_7270;
  localparam logic [TEXT_W-1:0] KW_PRINT    = 64'h0000_0074_6E69_7270;
  localparam logic [CNT_W-1:0]  KW_SPAWN_LEN    = 4'd5;
  localparam logic [CNT_W-1:0]  KW_EVOLVE_LEN   = 4'd6;
  localparam logic [CNT_W-1:0]  KW_FITNESS_LEN  = 4'd7;
  localparam logic [CNT_W-1:0]  KW_PRESSURE_LEN = 4'd8;
  localparam logic [CNT_W-1:0]  KW_PRINT_LEN    = 4'd5;

  typedef struct packed {
    logic [4:0]        token_kind;
    logic signed [31:0] number_value;
    logic [TEXT_W-1:0] ident_text;
    logic [CNT_W-1:0]  ident_length;
    logic              ident_truncated;
    logic              last_of_run;
  } token_t;

  // results of one accepted byte, in order
  typedef struct packed {
    logic [1:0] count;
    token_t     tok0;
    token_t     tok1;
  } push_t;

  function automatic logic [4:0] kw_kind(logic [TEXT_W-1:0] text, logic [CNT_W-1:0] len,
                                         logic ovf);
    logic [4:0] k;
    k = KIND_IDENT;
    if (!ovf) begin
      if (len == KW_SPAWN_LEN && text == KW_SPAWN) k = KIND_SPAWN;
      else if (len == KW_EVOLVE_LEN && text == KW_EVOLVE) k = KIND_EVOLVE;
      else if (len == KW_FITNESS_LEN && text == KW_FITNESS) k = KIND_FITNESS;
      else if (len == KW_PRESSURE_LEN && text == KW_PRESSURE) k = KIND_PRESSURE;
      else if (len == KW_PRINT_LEN && text == KW_PRINT) k = KIND_PRINT;
    end
    return k;
  endfunction

  function automatic logic [4:0] sym_kind(logic [7:0] c);
    logic [4:0] k;
    case (c)
      "[":     k = KIND_LBRACK;
      "]":     k = KIND_RBRACK;
      "(":     k = KIND_LPAREN;
      ")":     k = KIND_RPAREN;
      "+":     k = KIND_PLUS;
      "-":     k = KIND_MINUS;
      "*":     k = KIND_STAR;
      "/":     k = KIND_SLASH;
      "=":     k = KIND_EQUAL;
      default: k = KIND_END;
    endcase
    return k;
  endfunction

endpackage

[design/kns_if.sv]
interface kns_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;

  modport source (output valid, output char_in, input ready);
  modport sink (input valid, input char_in, output ready);
endinterface

interface kns_token_if;
  import kns_pkg::*;
  logic               valid;
  logic               ready;
  logic [4:0]         token_kind;
  logic signed [31:0] number_value;
  logic [TEXT_W-1:0]  ident_text;
  logic [CNT_W-1:0]   ident_length;
  logic               ident_truncated;
  logic               last_of_run;

  modport source (output valid, output token_kind, output number_value, output ident_text,
                  output ident_length, output ident_truncated, output last_of_run,
                  input ready);
  modport sink (input valid, input token_kind, input number_value, input ident_text,
                input ident_length, input ident_truncated, input last_of_run,
                output ready);
endinterface

[design/keyword_number_symbol_lexer.sv]
// keyword / number / symbol lexer
//
// src_i carries one source byte per transfer (char_in); a zero byte ends the
// text. tok_o carries tokens: kind, number value, identifier text, length,
// truncation flag and last_of_run, which marks the final token of a byte.
//
// latency: the first token caused by a byte is shown on tok_o in the cycle
// after the byte's transfer when no older token waits ahead of it.
// throughput: one byte per cycle while src_i.ready is high; the scanner does
// the digit accumulate, identifier append and keyword compare combinationally.
// a byte that both closes a pending token and emits one of its own pushes
// two tokens into the three-entry result queue; src_i.ready drops while
// the queue holds two or more tokens, which stalls src_i even when the
// receiver takes a token every cycle. a stalled receiver holds the source
// off with at most three tokens queued, and no token is lost.
// reset: the scanner returns to idle with empty buffers; the queue empties.
module keyword_number_symbol_lexer (
  input logic          clk_i,
  input logic          rst_ni,
  kns_byte_if.sink     src_i,
  kns_token_if.source  tok_o
);
  import kns_pkg::*;

  logic   byte_xfer;   // byte transfer on src_i
  logic   tok_xfer;    // token transfer on tok_o
  logic   space;
  push_t  push;
  token_t head;

  assign src_i.ready = space;
  assign byte_xfer   = src_i.valid && space;
  assign tok_xfer    = tok_o.valid && tok_o.ready;

  // scanner state and the tokens each byte produces
  kns_scan u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .char_i   (src_i.char_in),
    .accept_i (byte_xfer),
    .push_o   (push)
  );

  // result queue decouples the scanner from receiver stalls
  kns_tokq u_tokq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (tok_xfer),
    .head_o  (head),
    .valid_o (tok_o.valid),
    .space_o (space)
  );

  assign tok_o.token_kind      = head.token_kind;
  assign tok_o.number_value    = head.number_value;
  assign tok_o.ident_text      = head.ident_text;
  assign tok_o.ident_length    = head.ident_length;
  assign tok_o.ident_truncated = head.ident_truncated;
  assign tok_o.last_of_run     = head.last_of_run;

endmodule

[design/kns_scan.sv]
module kns_scan (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [7:0]    char_i,
  input  logic          accept_i,
  output kns_pkg::push_t push_o
);
  import kns_pkg::*;

  logic [1:0]                  mode_q, mode_d;
  logic [31:0]                 acc_q, acc_d;
  logic [IDENT_BYTES-1:0][7:0] ident_q, ident_d;
  logic [CNT_W-1:0]            cnt_q, cnt_d;
  logic                        ovf_q, ovf_d;

  logic        is_space, is_digit, is_word;
  logic [31:0] digit, acc_x10;
  logic        has_close, has_byte;
  token_t      tok_close, tok_byte;

  assign is_space = (char_i == 8'd32) || (char_i >= 8'd9 && char_i <= 8'd13);
  assign is_digit = (char_i >= "0") && (char_i <= "9");
  assign is_word  = (char_i >= "a" && char_i <= "z") || (char_i >= "A" && char_i <= "Z") ||
                    (char_i == "_");
  assign digit    = {28'd0, char_i[3:0]};
  // times ten as two shifts
  assign acc_x10  = {acc_q[28:0], 3'b000} + {acc_q[30:0], 1'b0};

  always_comb begin
    mode_d    = mode_q;
    acc_d     = acc_q;
    ident_d   = ident_q;
    cnt_d     = cnt_q;
    ovf_d     = ovf_q;
    has_close = 1'b0;
    has_byte  = 1'b0;
    tok_close = '0;
    tok_byte  = '0;
    if (mode_q == MODE_NUM && is_digit) begin
      acc_d = acc_x10 + digit;
    end else if (mode_q == MODE_IDENT && is_word) begin
      if (cnt_q < CNT_W'(IDENT_BYTES)) begin
        ident_d[cnt_q[IDX_W-1:0]] = char_i;
        cnt_d = cnt_q + 1'b1;
      end else begin
        ovf_d = 1'b1;
      end
    end else begin
      unique case (mode_q)
        MODE_NUM: begin
          has_close              = 1'b1;
          tok_close.token_kind   = KIND_NUMBER;
          tok_close.number_value = acc_q;
        end
        MODE_IDENT: begin
          has_close                 = 1'b1;
          tok_close.token_kind      = kw_kind(ident_q, cnt_q, ovf_q);
          tok_close.ident_text      = ident_q;
          tok_close.ident_length    = cnt_q;
          tok_close.ident_truncated = ovf_q;
        end
        default: ;
      endcase
      mode_d  = MODE_IDLE;
      acc_d   = '0;
      ident_d = '0;
      cnt_d   = '0;
      ovf_d   = 1'b0;
      if (char_i == CHAR_NUL) begin
        has_byte = 1'b1;
        tok_byte.token_kind = KIND_END;
      end else if (is_space) begin
        has_byte = 1'b0;
      end else if (is_digit) begin
        mode_d = MODE_NUM;
        acc_d  = digit;
      end else if (is_word) begin
        mode_d     = MODE_IDENT;
        ident_d[0] = char_i;
        cnt_d      = CNT_W'(1);
      end else begin
        // symbols, and unknown bytes as end kind
        has_byte = 1'b1;
        tok_byte.token_kind = sym_kind(char_i);
      end
    end
  end

  always_comb begin
    push_o      = '0;
    push_o.tok1 = tok_byte;
    push_o.tok1.last_of_run = 1'b1;
    if (has_close) begin
      push_o.tok0 = tok_close;
      push_o.tok0.last_of_run = !has_byte;
    end else begin
      push_o.tok0 = tok_byte;
      push_o.tok0.last_of_run = 1'b1;
    end
    if (accept_i) begin
      push_o.count = {1'b0, has_close} + {1'b0, has_byte};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      acc_q   <= '0;
      ident_q <= '0;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
    end else if (accept_i) begin
      mode_q  <= mode_d;
      acc_q   <= acc_d;
      ident_q <= ident_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
    end
  end

endmodule

[design/kns_tokq.sv]
module kns_tokq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  kns_pkg::push_t  push_i,
  input  logic            pop_i,
  output kns_pkg::token_t head_o,
  output logic            valid_o,
  output logic            space_o
);
  import kns_pkg::*;

  localparam int unsigned QDEPTH = 3;

  token_t     ent_q [QDEPTH];
  token_t     ent_d [QDEPTH];
  logic [1:0] count_q, count_d, base;

  assign head_o  = ent_q[0];
  assign valid_o = (count_q != 2'd0);
  // room for two results after any pop
  assign space_o = (count_q <= 2'd1);

  always_comb begin
    ent_d = ent_q;
    base  = count_q - {1'b0, pop_i};
    if (pop_i) begin
      ent_d[0] = ent_q[1];
      ent_d[1] = ent_q[2];
    end
    if (push_i.count != 2'd0) begin
      ent_d[base] = push_i.tok0;
    end
    if (push_i.count == 2'd2) begin
      ent_d[base + 2'd1] = push_i.tok1;
    end
    count_d = base + push_i.count;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

endmodule

[design/kns_checker.sv]
module kns_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [4:0]                token_kind_i,
  input logic signed [31:0]        number_value_i,
  input logic [kns_pkg::TEXT_W-1:0] ident_text_i,
  input logic [kns_pkg::CNT_W-1:0]  ident_length_i,
  input logic                      ident_truncated_i
);
  import kns_pkg::*;

  logic xfer;
  assign xfer = out_valid_i && out_ready_i;

  // only number tokens carry a value
  a_value_only_number: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (xfer && token_kind_i != KIND_NUMBER) |-> (number_value_i == 32'sd0))
    else $error("value on a non-number token");

  // truncation means a full buffer and a plain identifier
  a_trunc_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (xfer && ident_truncated_i) |->
      (ident_length_i == CNT_W'(IDENT_BYTES) && token_kind_i == KIND_IDENT))
    else $error("truncated token not a full identifier");

  // text and length only on identifiers and keywords
  a_text_only_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (xfer && (token_kind_i < KIND_IDENT || token_kind_i > KIND_PRINT)) |->
      (ident_length_i == '0 && ident_text_i == '0 && !ident_truncated_i))
    else $error("identifier fields on a non-word token");

  // a stalled token stays offered
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("token withdrawn while stalled");

endmodule

bind keyword_number_symbol_lexer kns_checker u_kns_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_i       (tok_o.valid),
  .out_ready_i       (tok_o.ready),
  .token_kind_i      (tok_o.token_kind),
  .number_value_i    (tok_o.number_value),
  .ident_text_i      (tok_o.ident_text),
  .ident_length_i    (tok_o.ident_length),
  .ident_truncated_i (tok_o.ident_truncated)
);
